// ===== rtl/waypoint_dedup_min_queue_defines.svh =====
// Assertion macros shared by the waypoint queue RTL.
// Depends on nothing; users must have i_clk and i_rst_n in scope.
`ifndef WAYPOINT_DEDUP_MIN_QUEUE_DEFINES_SVH
`define WAYPOINT_DEDUP_MIN_QUEUE_DEFINES_SVH

// same-cycle implication
`define WDMQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WDMQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wdmq_pkg.sv =====
// Shared types and constants of the waypoint dedup queue.
// No dependencies.
package wdmq_pkg;

    localparam int REG_W   = 23;
    localparam int CFG_NUM = 5;
    localparam int ADDR_W  = 5;
    localparam int PDATA_W = 32;

    localparam int DEF_PENDING_DEPTH = 16;
    localparam int DEF_HISTORY_DEPTH = 64;
    localparam int DEF_COORD_WIDTH   = 24;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [REG_W-1:0] RST_WIN_LO  = 23'd128;
    localparam logic [REG_W-1:0] RST_WIN_HI  = 23'd768;
    localparam logic [REG_W-1:0] RST_MERGE   = 23'd256;
    localparam logic [REG_W-1:0] RST_REPEAT  = 23'd128;
    localparam logic [REG_W-1:0] RST_OFFSET  = 23'd128;
    localparam int               RST_GOAL    = 26;

    // register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_WIN_LO  = 3'd0,
        REG_WIN_HI  = 3'd1,
        REG_MERGE   = 3'd2,
        REG_REPEAT  = 3'd3,
        REG_OFFSET  = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_ROBOT  = 2'd0,
        MODE_GOAL   = 2'd1,
        MODE_DETECT = 2'd2,
        MODE_TICK   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [REG_W-1:0] win_lo;
        logic [REG_W-1:0] win_hi;
        logic [REG_W-1:0] merge_tol;
        logic [REG_W-1:0] repeat_tol;
        logic [REG_W-1:0] offset;
    } t_cfg;

endpackage

// ===== rtl/wdmq_fifo.sv =====
// Short queue between the classifying front end and the scan engine.
// Depends on nothing.
module wdmq_fifo #(
    parameter int W     = 26,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ===== rtl/wdmq_front.sv =====
// Front end: takes input words, drops detections outside the window.
// Depends on wdmq_pkg.
module wdmq_front import wdmq_pkg::*; #(
    parameter int CW = DEF_COORD_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_mode,
    input  logic [CW-1:0] i_coord,
    input  t_cfg          i_cfg,
    output logic          o_push,
    output logic [CW+1:0] o_push_data,
    input  logic          i_full
);
    localparam int XW = ((CW > REG_W) ? CW : REG_W) + 1;

    logic          r_vld;
    t_mode         r_mode;
    logic [CW-1:0] r_coord;

    logic signed [XW-1:0] c_ext, lo_ext, hi_ext;
    logic                 keep, drain;

    // window test, both bounds exclusive
    assign c_ext  = XW'(signed'(r_coord));
    assign lo_ext = signed'(XW'(i_cfg.win_lo));
    assign hi_ext = signed'(XW'(i_cfg.win_hi));
    assign keep   = (r_mode != MODE_DETECT) || ((c_ext > lo_ext) && (c_ext < hi_ext));

    assign o_push      = r_vld && keep && !i_full;
    assign drain       = r_vld && (!keep || !i_full);
    assign o_ready     = !r_vld || drain;
    assign o_push_data = {r_mode, r_coord};

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mode  <= t_mode'(i_mode);
            r_coord <= i_coord;
        end
    end
endmodule

// ===== rtl/wdmq_back.sv =====
// Scan engine: pending table, history ring and output register.
// Depends on wdmq_pkg and waypoint_dedup_min_queue_defines.svh.
`include "waypoint_dedup_min_queue_defines.svh"
module wdmq_back import wdmq_pkg::*; #(
    parameter int CW = DEF_COORD_WIDTH,
    parameter int PD = DEF_PENDING_DEPTH,
    parameter int HD = DEF_HISTORY_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  logic [CW+1:0] i_data,
    output logic          o_pop,
    input  t_cfg          i_cfg,
    output logic          o_valid,
    output logic [CW-1:0] o_data,
    input  logic          i_ready
);
    localparam int PIW = $clog2(PD);
    localparam int HIW = $clog2(HD);
    localparam int HCW = $clog2(HD + 1);
    localparam int SIW = (PIW > HIW) ? PIW : HIW;
    localparam int EW  = ((CW > REG_W) ? CW : REG_W) + 2;
    localparam int DW  = ((CW + 1) > REG_W) ? (CW + 1) : REG_W;
    localparam logic signed [EW-1:0] C_MAX = signed'(EW'({1'b0, {(CW-1){1'b1}}}));
    localparam logic signed [EW-1:0] C_MIN = -C_MAX - 1;

    typedef enum logic [2:0] {
        S_IDLE, S_DSCAN, S_DDONE, S_PSCAN, S_PDONE, S_HSCAN, S_HDONE
    } t_state;

    t_state               r_state;
    logic signed [CW-1:0] r_robot, r_goal, r_new, r_best_val;
    logic [PD-1:0]        r_pnd_vld;
    logic signed [CW-1:0] pnd_mem [PD];
    logic signed [CW-1:0] his_mem [HD];
    logic signed [CW-1:0] r_pnd_q, r_his_q;
    logic [HIW-1:0]       r_his_next;
    logic [HCW-1:0]       r_his_cnt;
    logic [SIW-1:0]       r_idx, r_cmp_idx;
    logic                 r_issue, r_cmp_vld, r_hit;
    logic                 r_free_ok, r_best_ok;
    logic [PIW-1:0]       r_free_idx, r_best_idx;
    logic                 r_out_valid;
    logic [CW-1:0]        r_out_data;

    t_mode                in_mode;
    logic signed [CW-1:0] in_coord, det_abs, emit_val;
    logic [SIW-1:0]       last_idx;
    logic                 scan_end, out_free, pnd_we, his_we;
    logic [PIW-1:0]       p_idx;

    function automatic logic signed [CW-1:0] sat(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] t;
        t = (v > C_MAX) ? C_MAX : ((v < C_MIN) ? C_MIN : v);
        return signed'(t[CW-1:0]);
    endfunction

    function automatic logic [DW-1:0] absdiff(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
        logic signed [CW:0] d;
        d = (CW+1)'(a) - (CW+1)'(b);
        return DW'(unsigned'((d < 0) ? -d : d));
    endfunction

    assign in_mode  = t_mode'(i_data[CW+1:CW]);
    assign in_coord = signed'(i_data[CW-1:0]);
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign det_abs  = sat(EW'(in_coord) + EW'(r_robot));
    assign emit_val = sat(EW'(r_best_val) - signed'(EW'(i_cfg.offset)));
    assign last_idx = (r_state == S_HSCAN) ? SIW'(HD - 1) : SIW'(PD - 1);
    assign scan_end = r_cmp_vld && (r_cmp_idx == last_idx);
    assign p_idx    = r_cmp_idx[PIW-1:0];
    assign out_free = !r_out_valid || i_ready;
    assign pnd_we   = (r_state == S_DDONE) && !r_hit && r_free_ok;
    assign his_we   = (r_state == S_HDONE) && !r_hit && out_free;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;

    // pending memory, one registered read port
    always_ff @(posedge i_clk) begin
        if (pnd_we) begin
            pnd_mem[r_free_idx] <= r_new;
        end
        r_pnd_q <= pnd_mem[r_idx[PIW-1:0]];
    end

    // history memory, one registered read port
    always_ff @(posedge i_clk) begin
        if (his_we) begin
            his_mem[r_his_next] <= r_best_val;
        end
        r_his_q <= his_mem[r_idx[HIW-1:0]];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_robot     <= '0;
            r_goal      <= CW'(RST_GOAL);
            r_pnd_vld   <= '0;
            r_his_next  <= '0;
            r_his_cnt   <= '0;
            r_issue     <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_cmp_idx   <= '0;
        end else begin
            // address issue, one entry per cycle
            r_cmp_vld <= r_issue;
            if (r_issue) begin
                r_cmp_idx <= r_idx;
                if (r_idx == last_idx) begin
                    r_issue <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            // output word taken and no new one loaded
            if (r_out_valid && i_ready && !his_we) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        unique case (in_mode)
                            MODE_ROBOT: r_robot <= in_coord;
                            MODE_GOAL:  r_goal  <= in_coord;
                            MODE_DETECT: begin
                                if (det_abs <= r_goal) begin
                                    r_new     <= det_abs;
                                    r_hit     <= 1'b0;
                                    r_free_ok <= 1'b0;
                                    r_idx     <= '0;
                                    r_issue   <= 1'b1;
                                    r_state   <= S_DSCAN;
                                end
                            end
                            MODE_TICK: begin
                                r_best_ok <= 1'b0;
                                r_idx     <= '0;
                                r_issue   <= 1'b1;
                                r_state   <= S_PSCAN;
                            end
                        endcase
                    end
                end
                // duplicate check and first free slot
                S_DSCAN: begin
                    if (r_cmp_vld) begin
                        if (r_pnd_vld[p_idx]) begin
                            if (absdiff(r_pnd_q, r_new) < DW'(i_cfg.merge_tol)) begin
                                r_hit <= 1'b1;
                            end
                        end else if (!r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= p_idx;
                        end
                    end
                    if (scan_end) begin
                        r_state <= S_DDONE;
                    end
                end
                S_DDONE: begin
                    if (pnd_we) begin
                        r_pnd_vld[r_free_idx] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                // smallest entry, lowest slot wins ties
                S_PSCAN: begin
                    if (r_cmp_vld && r_pnd_vld[p_idx] &&
                        (!r_best_ok || (r_pnd_q < r_best_val))) begin
                        r_best_ok  <= 1'b1;
                        r_best_idx <= p_idx;
                        r_best_val <= r_pnd_q;
                    end
                    if (scan_end) begin
                        r_state <= S_PDONE;
                    end
                end
                S_PDONE: begin
                    if (r_best_ok) begin
                        r_pnd_vld[r_best_idx] <= 1'b0;
                        r_hit   <= 1'b0;
                        r_idx   <= '0;
                        r_issue <= 1'b1;
                        r_state <= S_HSCAN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                // repeat check against the filled part of the ring
                S_HSCAN: begin
                    if (r_cmp_vld && (HCW'(r_cmp_idx[HIW-1:0]) < r_his_cnt) &&
                        (absdiff(r_his_q, r_best_val) < DW'(i_cfg.repeat_tol))) begin
                        r_hit <= 1'b1;
                    end
                    if (scan_end) begin
                        r_state <= S_HDONE;
                    end
                end
                S_HDONE: begin
                    if (r_hit) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= unsigned'(emit_val);
                        r_his_next  <= (r_his_next == HIW'(HD - 1)) ? '0 : r_his_next + 1'b1;
                        if (r_his_cnt != HCW'(HD)) begin
                            r_his_cnt <= r_his_cnt + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `WDMQ_ASSERT_IMP(a_pop_idle, o_pop, r_state == S_IDLE, "pop outside idle")
    `WDMQ_ASSERT_IMP(a_his_cnt, 1'b1, r_his_cnt <= HCW'(HD), "history count overflow")
    `WDMQ_ASSERT_IMP(a_pnd_free, pnd_we, !r_pnd_vld[r_free_idx], "write to busy slot")
    `WDMQ_ASSERT_NXT(a_emit_src, !r_out_valid && !his_we, !r_out_valid, "result without emit")
endmodule

// ===== rtl/waypoint_dedup_min_queue.sv =====
// Top level of the waypoint dedup queue: config registers and wiring.
// Depends on wdmq_pkg, wdmq_front, wdmq_fifo, wdmq_back.
//
// Usage: input words arrive on the s_axis channel (tuser = mode, tdata =
// coordinate). Mode 0 sets the robot position, mode 1 the goal, mode 2 offers
// a relative detection, mode 3 is a tick that may release one waypoint on
// the m_axis channel. Five registers sit on the APB port at 4*index.
// A detection scans the pending table, one pending entry read per cycle; a
// tick that emits scans the pending table, then the history ring, one memory
// read per cycle each, before tvalid rises. The scan engine handles one word
// at a time; a detection inside the window holds it through the pending scan,
// a tick through both scans, while a position load needs no scan.
// A four-word queue lets the input side keep accepting while the engine
// scans. The result sits in an output register; while the receiver stalls,
// the engine holds the next emission and the queue fills, then tready drops.
// Reset (synchronous, active low) empties the pending table, history ring,
// queue and output register, and loads register and position defaults.
module waypoint_dedup_min_queue import wdmq_pkg::*; #(
    parameter int PENDING_DEPTH = DEF_PENDING_DEPTH,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
    localparam int TDW          = ((COORD_WIDTH + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDW-1:0]     i_s_axis_tdata,   // [COORD_WIDTH-1:0] coord
    input  logic [1:0]         i_s_axis_tuser,   // [1:0] mode
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDW-1:0]     o_m_axis_tdata,   // [COORD_WIDTH-1:0] waypoint less offset
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [ADDR_W-1:0]  i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output logic [PDATA_W-1:0] o_prdata,
    output logic               o_pready
);
    t_cfg                   r_cfg;
    t_reg_idx               reg_idx;
    logic                   cfg_we;
    logic                   push, full, pop, empty;
    logic [COORD_WIDTH+1:0] push_data, pop_data;
    logic [COORD_WIDTH-1:0] mid;

    // register file
    assign reg_idx  = t_reg_idx'(i_paddr[4:2]);
    assign cfg_we   = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_lo     <= RST_WIN_LO;
            r_cfg.win_hi     <= RST_WIN_HI;
            r_cfg.merge_tol  <= RST_MERGE;
            r_cfg.repeat_tol <= RST_REPEAT;
            r_cfg.offset     <= RST_OFFSET;
        end else if (cfg_we) begin
            unique case (reg_idx)
                REG_WIN_LO: r_cfg.win_lo     <= i_pwdata[REG_W-1:0];
                REG_WIN_HI: r_cfg.win_hi     <= i_pwdata[REG_W-1:0];
                REG_MERGE:  r_cfg.merge_tol  <= i_pwdata[REG_W-1:0];
                REG_REPEAT: r_cfg.repeat_tol <= i_pwdata[REG_W-1:0];
                REG_OFFSET: r_cfg.offset     <= i_pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    // readback
    always_comb begin
        unique case (reg_idx)
            REG_WIN_LO: o_prdata = PDATA_W'(r_cfg.win_lo);
            REG_WIN_HI: o_prdata = PDATA_W'(r_cfg.win_hi);
            REG_MERGE:  o_prdata = PDATA_W'(r_cfg.merge_tol);
            REG_REPEAT: o_prdata = PDATA_W'(r_cfg.repeat_tol);
            REG_OFFSET: o_prdata = PDATA_W'(r_cfg.offset);
            default:    o_prdata = '0;
        endcase
    end

    wdmq_front #(.CW(COORD_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_mode      (i_s_axis_tuser),
        .i_coord     (i_s_axis_tdata[COORD_WIDTH-1:0]),
        .i_cfg       (r_cfg),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    wdmq_fifo #(.W(COORD_WIDTH + 2), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (pop_data)
    );

    wdmq_back #(.CW(COORD_WIDTH), .PD(PENDING_DEPTH), .HD(HISTORY_DEPTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_data  (pop_data),
        .o_pop   (pop),
        .i_cfg   (r_cfg),
        .o_valid (o_m_axis_tvalid),
        .o_data  (mid),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = TDW'(mid);
endmodule
